### rtl/flow_timing_length_statistics_top_defines.svh
// Assertion macros used by the checker file of the flow statistics block
`ifndef FLOW_TIMING_LENGTH_STATISTICS_TOP_DEFINES_SVH
`define FLOW_TIMING_LENGTH_STATISTICS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define FTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define FTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fts_pkg.sv
// Package: widths, codes and the end-of-flow step table of the flow statistics block
`timescale 1ns / 1ps
package fts_pkg;

  localparam int TS_W   = 40;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 16;
  localparam int BYTE_W = 32;
  localparam int LSQ_W  = 48;
  localparam int OUT_TW = 40;

  localparam int MAX_PACKETS_DEF = 65535;
  localparam int TIME_BITS_DEF   = 40;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd11;

  // accumulator load sources
  localparam logic [1:0] ACC_ZERO = 2'd0;
  localparam logic [1:0] ACC_Q    = 2'd1;
  localparam logic [1:0] ACC_LQ   = 2'd2;
  localparam logic [1:0] ACC_KEEP = 2'd3;

  // operand A load sources
  localparam logic [2:0] OPA_KEEP = 3'd0;
  localparam logic [2:0] OPA_G    = 3'd1;
  localparam logic [2:0] OPA_L    = 3'd2;
  localparam logic [2:0] OPA_MG   = 3'd3;
  localparam logic [2:0] OPA_ML   = 3'd4;
  localparam logic [2:0] OPA_MG2  = 3'd5;
  localparam logic [2:0] OPA_ML2  = 3'd6;
  localparam logic [2:0] OPA_ACC  = 3'd7;

  // operand B load sources
  localparam logic [2:0] OPB_ZERO = 3'd0;
  localparam logic [2:0] OPB_MG   = 3'd1;
  localparam logic [2:0] OPB_ML   = 3'd2;
  localparam logic [2:0] OPB_NM1  = 3'd3;
  localparam logic [2:0] OPB_N    = 3'd4;
  localparam logic [2:0] OPB_G    = 3'd5;
  localparam logic [2:0] OPB_L    = 3'd6;

  // serial unit operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_MSUB = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;
  localparam logic [1:0] OP_SQRT = 2'd3;

  // result destinations
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_MG   = 3'd1;
  localparam logic [2:0] ST_ML   = 3'd2;
  localparam logic [2:0] ST_GDEV = 3'd3;
  localparam logic [2:0] ST_LDEV = 3'd4;

  typedef struct packed {
    logic [1:0] acc_sel;
    logic [2:0] opa_sel;
    logic [2:0] opb_sel;
    logic [1:0] op;
    logic [2:0] st;
  } fts_step_t;

  typedef struct packed {
    logic       idle;
    logic       sq_on;
    logic [1:0] sq_phase;
    logic       load;
    logic       run;
    logic       store;
    logic       emit;
    fts_step_t  step;
  } fts_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } fts_stat_t;

  function automatic fts_step_t fts_step(input logic [STEP_W-1:0] s);
    fts_step_t r;
    r = '{acc_sel: ACC_ZERO, opa_sel: OPA_KEEP, opb_sel: OPB_ZERO, op: OP_MUL, st: ST_NONE};
    case (s)
      4'd0:  r = '{ACC_ZERO, OPA_G,    OPB_ZERO, OP_DIV,  ST_MG};
      4'd1:  r = '{ACC_ZERO, OPA_L,    OPB_ZERO, OP_DIV,  ST_ML};
      4'd2:  r = '{ACC_ZERO, OPA_MG,   OPB_MG,   OP_MUL,  ST_NONE};
      4'd3:  r = '{ACC_Q,    OPA_ACC,  OPB_NM1,  OP_MUL,  ST_NONE};
      4'd4:  r = '{ACC_KEEP, OPA_MG2,  OPB_G,    OP_MSUB, ST_NONE};
      4'd5:  r = '{ACC_ZERO, OPA_ACC,  OPB_ZERO, OP_DIV,  ST_NONE};
      4'd6:  r = '{ACC_ZERO, OPA_KEEP, OPB_ZERO, OP_SQRT, ST_GDEV};
      4'd7:  r = '{ACC_ZERO, OPA_ML,   OPB_ML,   OP_MUL,  ST_NONE};
      4'd8:  r = '{ACC_LQ,   OPA_ACC,  OPB_N,    OP_MUL,  ST_NONE};
      4'd9:  r = '{ACC_KEEP, OPA_ML2,  OPB_L,    OP_MSUB, ST_NONE};
      4'd10: r = '{ACC_ZERO, OPA_ACC,  OPB_ZERO, OP_DIV,  ST_NONE};
      4'd11: r = '{ACC_ZERO, OPA_KEEP, OPB_ZERO, OP_SQRT, ST_LDEV};
      default: r = '{ACC_ZERO, OPA_KEEP, OPB_ZERO, OP_MUL, ST_NONE};
    endcase
    return r;
  endfunction

endpackage

### rtl/fts_if.sv
// Interfaces: packet channel and result channel of the flow statistics block
`timescale 1ns / 1ps
interface fts_packet_if import fts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TS_W-1:0]   timestamp_us;
  logic [LEN_W-1:0]  packet_length;
  logic              last;

  modport source (output valid, timestamp_us, packet_length, last, input ready);
  modport sink   (input valid, timestamp_us, packet_length, last, output ready);
endinterface

interface fts_result_if import fts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  packet_count;
  logic [BYTE_W-1:0] byte_total;
  logic [OUT_TW-1:0] duration_us;
  logic [OUT_TW-1:0] min_gap;
  logic [OUT_TW-1:0] mean_gap;
  logic [OUT_TW-1:0] max_gap;
  logic [OUT_TW-1:0] gap_deviation;
  logic [LEN_W-1:0]  min_length;
  logic [LEN_W-1:0]  mean_length;
  logic [LEN_W-1:0]  max_length;
  logic [LEN_W-1:0]  length_deviation;
  logic              overflow;

  modport source (output valid, packet_count, byte_total, duration_us, min_gap, mean_gap,
                  max_gap, gap_deviation, min_length, mean_length, max_length,
                  length_deviation, overflow, input ready);
  modport sink   (input valid, packet_count, byte_total, duration_us, min_gap, mean_gap,
                  max_gap, gap_deviation, min_length, mean_length, max_length,
                  length_deviation, overflow, output ready);
endinterface

### rtl/fts_ctrl.sv
// Controller: sequences packet accumulation and the end-of-flow arithmetic steps
`timescale 1ns / 1ps
module fts_ctrl import fts_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  fts_stat_t stat,
  output fts_cmd_t  cmd
);

  localparam int SW   = 2 * TIME_BITS + 16;
  localparam int IT_W = $clog2(SW + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [1:0]        phase;
  logic [STEP_W-1:0] step;
  logic [IT_W-1:0]   iter;
  fts_step_t         cur;

  assign cur = fts_step(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= '0;
      step  <= '0;
      iter  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_SQ;
            phase <= '0;
          end
        end
        S_SQ: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            step  <= '0;
            state <= stat.last ? S_LOAD : S_IDLE;
          end
        end
        S_LOAD: begin
          iter  <= (cur.op == OP_SQRT) ? IT_W'(SW / 2 - 1) : IT_W'(SW - 1);
          state <= S_RUN;
        end
        S_RUN: begin
          iter <= iter - 1'b1;
          if (iter == '0) state <= S_STORE;
        end
        S_STORE: begin
          if (step == LAST_STEP) begin
            state <= S_DONE;
          end else begin
            step  <= step + 1'b1;
            state <= S_LOAD;
          end
        end
        S_DONE: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.step     = cur;
    cmd.idle     = (state == S_IDLE);
    cmd.sq_on    = (state == S_SQ);
    cmd.sq_phase = phase;
    cmd.load     = (state == S_LOAD);
    cmd.run      = (state == S_RUN);
    cmd.store    = (state == S_STORE);
    cmd.emit     = (state == S_DONE) && stat.out_free;
  end

endmodule

### rtl/fts_datapath.sv
// Datapath: running sums and extremes, serial mul/div/sqrt unit, result register
`timescale 1ns / 1ps
module fts_datapath import fts_pkg::*; #(
  parameter int MAX_PACKETS = MAX_PACKETS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  fts_cmd_t          cmd,
  output fts_stat_t         stat,
  input  logic              take,
  input  logic [TS_W-1:0]   timestamp_us,
  input  logic [LEN_W-1:0]  packet_length,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  packet_count,
  output logic [BYTE_W-1:0] byte_total,
  output logic [OUT_TW-1:0] duration_us,
  output logic [OUT_TW-1:0] min_gap,
  output logic [OUT_TW-1:0] mean_gap,
  output logic [OUT_TW-1:0] max_gap,
  output logic [OUT_TW-1:0] gap_deviation,
  output logic [LEN_W-1:0]  min_length,
  output logic [LEN_W-1:0]  mean_length,
  output logic [LEN_W-1:0]  max_length,
  output logic [LEN_W-1:0]  length_deviation,
  output logic              overflow
);

  localparam int TW = TIME_BITS;
  localparam int GW = TW + 16;
  localparam int SW = 2 * TW + 16;
  localparam int HW = (TW + 1) / 2;
  localparam int XW = (TW > TS_W) ? TW : TS_W;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_PACKETS);

  // flow state
  logic [CNT_W-1:0]  count;
  logic [TW-1:0]     first_t, prev_t, gmin, gmax;
  logic [GW-1:0]     gsum;
  logic [SW-1:0]     gsq;
  logic [BYTE_W-1:0] lsum;
  logic [LSQ_W-1:0]  lsq;
  logic [LEN_W-1:0]  lmin, lmax;
  logic              ovf, last_q;

  // squaring pipeline
  logic [TW-1:0]     greg;
  logic              sq_en;
  logic [2*HW-1:0]   prod;
  logic [1:0]        prod_sh;
  logic              prod_v;
  logic [2*LEN_W-1:0] lprod;
  logic              lprod_v;

  // serial unit and its results
  logic [SW-1:0]     acc, opa, opb;
  logic [TW-1:0]     mg, gdev;
  logic [LEN_W-1:0]  ml, ldev;

  logic [XW-1:0]     ts_x;
  logic [TW-1:0]     t, g;
  logic              upd;
  logic [HW-1:0]     glo, ghi, mul_a, mul_b;
  logic [SW-1:0]     prod_x;
  logic [SW-1:0]     nx, div_r, sq_r, sq_trial;
  logic              div_ge, sq_ge;

  assign ts_x = XW'(timestamp_us);
  assign t    = ts_x[TW-1:0];
  assign g    = t - prev_t;
  assign upd  = take && (count < MAXC);

  assign glo = greg[HW-1:0];
  assign ghi = HW'(greg >> HW);

  always_comb begin
    case (cmd.sq_phase)
      2'd0:    begin mul_a = glo; mul_b = glo; end
      2'd1:    begin mul_a = glo; mul_b = ghi; end
      default: begin mul_a = ghi; mul_b = ghi; end
    endcase
    case (prod_sh)
      2'd0:    prod_x = SW'(prod);
      2'd1:    prod_x = SW'(prod) << (HW + 1);
      default: prod_x = SW'(prod) << (2 * HW);
    endcase
  end

  assign nx       = SW'(count);
  assign div_r    = {acc[SW-2:0], opa[SW-1]};
  assign div_ge   = (div_r >= nx);
  assign sq_r     = {acc[SW-3:0], opa[SW-1:SW-2]};
  assign sq_trial = {opb[SW-3:0], 2'b01};
  assign sq_ge    = (sq_r >= sq_trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      first_t <= '0;
      prev_t  <= '0;
      gsum    <= '0;
      gsq     <= '0;
      gmin    <= '1;
      gmax    <= '0;
      lsum    <= '0;
      lsq     <= '0;
      lmin    <= '1;
      lmax    <= '0;
      ovf     <= 1'b0;
      last_q  <= 1'b0;
      sq_en   <= 1'b0;
      prod_v  <= 1'b0;
      lprod_v <= 1'b0;
    end else begin
      if (take) begin
        last_q <= last;
        sq_en  <= upd && (count != '0);
        if (!upd) ovf <= 1'b1;
      end
      if (upd) begin
        if (count == '0) begin
          first_t <= t;
        end else begin
          gsum <= gsum + GW'(g);
          if (g < gmin) gmin <= g;
          if (g > gmax) gmax <= g;
        end
        greg  <= g;
        prev_t <= t;
        lsum  <= lsum + BYTE_W'(packet_length);
        if (packet_length < lmin) lmin <= packet_length;
        if (packet_length > lmax) lmax <= packet_length;
        count <= count + 1'b1;
      end
      lprod   <= packet_length * packet_length;
      lprod_v <= upd;
      if (lprod_v) lsq <= lsq + LSQ_W'(lprod);

      // gap square: multiply one partial product, add the previous one
      prod    <= mul_a * mul_b;
      prod_sh <= cmd.sq_phase;
      prod_v  <= cmd.sq_on && sq_en && (cmd.sq_phase != 2'd3);
      if (prod_v) gsq <= gsq + prod_x;

      if (cmd.emit) begin
        count  <= '0;
        first_t <= '0;
        prev_t <= '0;
        gsum   <= '0;
        gsq    <= '0;
        gmin   <= '1;
        gmax   <= '0;
        lsum   <= '0;
        lsq    <= '0;
        lmin   <= '1;
        lmax   <= '0;
        ovf    <= 1'b0;
      end
    end
  end

  // serial multiply, divide and square root
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.step.acc_sel)
        ACC_ZERO: acc <= '0;
        ACC_Q:    acc <= gsq;
        ACC_LQ:   acc <= SW'(lsq);
        default:  acc <= acc;
      endcase
      case (cmd.step.opa_sel)
        OPA_G:   opa <= SW'(gsum);
        OPA_L:   opa <= SW'(lsum);
        OPA_MG:  opa <= SW'(mg);
        OPA_ML:  opa <= SW'(ml);
        OPA_MG2: opa <= SW'({mg, 1'b0});
        OPA_ML2: opa <= SW'({ml, 1'b0});
        OPA_ACC: opa <= acc;
        default: opa <= opa;
      endcase
      case (cmd.step.opb_sel)
        OPB_MG:  opb <= SW'(mg);
        OPB_ML:  opb <= SW'(ml);
        OPB_NM1: opb <= SW'(count - 1'b1);
        OPB_N:   opb <= SW'(count);
        OPB_G:   opb <= SW'(gsum);
        OPB_L:   opb <= SW'(lsum);
        default: opb <= '0;
      endcase
    end else if (cmd.run) begin
      case (cmd.step.op)
        OP_MUL, OP_MSUB: begin
          if (opb[0]) acc <= (cmd.step.op == OP_MSUB) ? acc - opa : acc + opa;
          opa <= {opa[SW-2:0], 1'b0};
          opb <= {1'b0, opb[SW-1:1]};
        end
        OP_DIV: begin
          acc <= div_ge ? div_r - nx : div_r;
          opa <= {opa[SW-2:0], div_ge};
        end
        default: begin
          acc <= sq_ge ? sq_r - sq_trial : sq_r;
          opb <= {opb[SW-2:0], sq_ge};
          opa <= {opa[SW-3:0], 2'b00};
        end
      endcase
    end
    if (cmd.store) begin
      case (cmd.step.st)
        ST_MG:   mg   <= opa[TW-1:0];
        ST_ML:   ml   <= opa[LEN_W-1:0];
        ST_GDEV: gdev <= opb[TW-1:0];
        ST_LDEV: ldev <= opb[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      packet_count     <= count;
      byte_total       <= lsum;
      duration_us      <= OUT_TW'(TW'(prev_t - first_t));
      min_gap          <= (count > 1) ? OUT_TW'(gmin) : '0;
      mean_gap         <= OUT_TW'(mg);
      max_gap          <= (count > 1) ? OUT_TW'(gmax) : '0;
      gap_deviation    <= OUT_TW'(gdev);
      min_length       <= lmin;
      mean_length      <= ml;
      max_length       <= lmax;
      length_deviation <= ldev;
      overflow         <= ovf;
    end
  end

  assign stat.last     = last_q;
  assign stat.out_free = !out_valid || out_ready;

endmodule

### rtl/flow_timing_length_statistics_top.sv
// Top level: per-flow timing and length statistics
`timescale 1ns / 1ps
// Usage:
//   packet (sink): one packet per transfer with timestamp_us, packet_length and last.
//   result (source): one summary per flow, sent after the packet with last set.
// Packet handling: after each transfer, a half-width multiplier squares the gap in
//   three partial products; packet.ready stays low until it has finished.
// End of flow: the closing packet is followed by twelve serial arithmetic steps
//   (shift-add multiply, restoring divide, digit-by-digit square root) on a
//   2*TIME_BITS+16 bit working register; each step is loaded, run and stored in
//   turn, and result.valid rises after the last step once the result register
//   is free.
// Packets past MAX_PACKETS enter no statistic; they set overflow, and last still ends the flow.
// Reset (rst, synchronous) clears all running sums and drops any pending result.
// A stalled result is held in its output register; the next flow's packets are
//   accepted meanwhile, but a second summary waits until the first is taken.
module flow_timing_length_statistics_top import fts_pkg::*; #(
  parameter int MAX_PACKETS = MAX_PACKETS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  fts_packet_if.sink   packet,
  fts_result_if.source result
);

  fts_cmd_t  cmd;
  fts_stat_t stat;
  logic      take;

  assign packet.ready = cmd.idle;
  assign take         = packet.valid && cmd.idle;

  fts_ctrl #(.TIME_BITS(TIME_BITS)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .stat (stat),
    .cmd  (cmd)
  );

  fts_datapath #(.MAX_PACKETS(MAX_PACKETS), .TIME_BITS(TIME_BITS)) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .take             (take),
    .timestamp_us     (packet.timestamp_us),
    .packet_length    (packet.packet_length),
    .last             (packet.last),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .packet_count     (result.packet_count),
    .byte_total       (result.byte_total),
    .duration_us      (result.duration_us),
    .min_gap          (result.min_gap),
    .mean_gap         (result.mean_gap),
    .max_gap          (result.max_gap),
    .gap_deviation    (result.gap_deviation),
    .min_length       (result.min_length),
    .mean_length      (result.mean_length),
    .max_length       (result.max_length),
    .length_deviation (result.length_deviation),
    .overflow         (result.overflow)
  );

endmodule

### rtl/fts_checker.sv
// Checker: port-level properties of the flow statistics block, bound to the top level
`timescale 1ns / 1ps
`include "flow_timing_length_statistics_top_defines.svh"
module fts_checker import fts_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CNT_W-1:0]  packet_count,
  input logic [BYTE_W-1:0] byte_total,
  input logic [OUT_TW-1:0] min_gap,
  input logic [OUT_TW-1:0] max_gap,
  input logic [LEN_W-1:0]  min_length,
  input logic [LEN_W-1:0]  mean_length,
  input logic [LEN_W-1:0]  max_length
);

  `FTS_ASSERT_NXT(a_valid_held, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `FTS_ASSERT_NXT(a_data_held, out_valid && !out_ready, $stable(packet_count) && $stable(byte_total), "result changed while stalled")
  `FTS_ASSERT_IMP(a_count_nonzero, out_valid, packet_count != '0, "summary with no packets")
  `FTS_ASSERT_IMP(a_length_order, out_valid, min_length <= mean_length && mean_length <= max_length, "length mean outside min/max")
  `FTS_ASSERT_IMP(a_gap_order, out_valid, min_gap <= max_gap, "min gap above max gap")

endmodule

bind flow_timing_length_statistics_top fts_checker u_fts_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .packet_count (result.packet_count),
  .byte_total   (result.byte_total),
  .min_gap      (result.min_gap),
  .max_gap      (result.max_gap),
  .min_length   (result.min_length),
  .mean_length  (result.mean_length),
  .max_length   (result.max_length)
);

### sim/tb_top.sv
// Testbench for the flow timing and length statistics block
`timescale 1ns / 1ps
module tb_top;
  import fts_pkg::*;

  localparam int N_PKTS = 65535;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 1500;

  typedef struct packed {
    logic [CNT_W-1:0]  packet_count;
    logic [BYTE_W-1:0] byte_total;
    logic [OUT_TW-1:0] duration_us;
    logic [OUT_TW-1:0] min_gap;
    logic [OUT_TW-1:0] mean_gap;
    logic [OUT_TW-1:0] max_gap;
    logic [OUT_TW-1:0] gap_deviation;
    logic [LEN_W-1:0]  min_length;
    logic [LEN_W-1:0]  mean_length;
    logic [LEN_W-1:0]  max_length;
    logic [LEN_W-1:0]  length_deviation;
    logic              overflow;
  } summary_t;

  typedef struct {
    logic [TS_W-1:0]  ts;
    logic [LEN_W-1:0] len;
    bit               last;
    bit               known;
    summary_t         sum;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  fts_packet_if pkt ();
  fts_result_if res ();

  flow_timing_length_statistics_top dut (.clk(clk), .rst(rst), .packet(pkt), .result(res));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // flow statistics predictor state
  int               pkt_cnt;
  logic [TS_W-1:0]  t_first, t_prev;
  logic [63:0]      gap_total, len_total, len_sq_total;
  logic [127:0]     gap_sq_total;
  logic [TS_W-1:0]  gap_lo, gap_hi;
  logic [LEN_W-1:0] len_lo, len_hi;
  bit               pkt_ovf;

  summary_t summaries_due[$];
  int       errors = 0;
  int       cycles = 0;
  bit       sender_burst = 0;

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r[63:0];
  endfunction

  task automatic clear_flow();
    pkt_cnt = 0; t_first = '0; t_prev = '0;
    gap_total = '0; gap_sq_total = '0; gap_lo = '1; gap_hi = '0;
    len_total = '0; len_sq_total = '0; len_lo = '1; len_hi = '0;
    pkt_ovf = 0;
  endtask

  // accumulate one packet; on last, produce the flow summary
  task automatic accumulate(input logic [TS_W-1:0] ts, input logic [LEN_W-1:0] len,
                            input bit last, output bit done, output summary_t s);
    logic [TS_W-1:0] g;
    logic [127:0]    n, mg, sg;
    logic [63:0]     ml, sl;
    done = 0;
    s = '0;
    if (pkt_cnt < N_PKTS) begin
      if (pkt_cnt == 0) t_first = ts;
      else begin
        g = ts - t_prev;
        gap_sq_total += 128'(g) * 128'(g);
        gap_total += 64'(g);
        if (g < gap_lo) gap_lo = g;
        if (g > gap_hi) gap_hi = g;
      end
      t_prev = ts;
      len_total += 64'(len);
      len_sq_total += 64'(len) * 64'(len);
      if (len < len_lo) len_lo = len;
      if (len > len_hi) len_hi = len;
      pkt_cnt++;
    end else pkt_ovf = 1;
    if (!last) return;
    n = 128'(pkt_cnt);
    mg = 128'(gap_total) / n;
    ml = len_total / 64'(pkt_cnt);
    sg = gap_sq_total + (n - 1) * mg * mg - 2 * mg * 128'(gap_total);
    sl = len_sq_total + 64'(pkt_cnt) * ml * ml - 2 * ml * len_total;
    s.packet_count     = pkt_cnt[CNT_W-1:0];
    s.byte_total       = len_total[BYTE_W-1:0];
    s.duration_us      = t_prev - t_first;
    s.min_gap          = pkt_cnt > 1 ? gap_lo : '0;
    s.mean_gap         = mg[OUT_TW-1:0];
    s.max_gap          = pkt_cnt > 1 ? gap_hi : '0;
    s.gap_deviation    = OUT_TW'(isqrt(sg / n));
    s.min_length       = len_lo;
    s.mean_length      = ml[LEN_W-1:0];
    s.max_length       = len_hi;
    s.length_deviation = LEN_W'(isqrt(128'(sl / 64'(pkt_cnt))));
    s.overflow         = pkt_ovf;
    done = 1;
    clear_flow();
  endtask

  task automatic send(input row_t r);
    int w;
    bit done;
    summary_t s;
    w = sender_burst ? 0 : $urandom_range(0, 8);
    if (w > 0) begin
      pkt.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    pkt.valid <= 1'b1;
    pkt.timestamp_us <= r.ts;
    pkt.packet_length <= r.len;
    pkt.last <= r.last;
    do @(posedge clk); while (!pkt.ready);
    accumulate(r.ts, r.len, r.last, done, s);
    if (done) summaries_due.push_back(r.known ? r.sum : s);
  endtask

  function automatic row_t mk(logic [TS_W-1:0] ts, logic [LEN_W-1:0] len, bit last);
    row_t r;
    r.ts = ts; r.len = len; r.last = last; r.known = 0; r.sum = '0;
    return r;
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // result side: random stalls, one long hold-off, field checks
  initial begin
    int w, taken;
    summary_t want, got;
    logic [63:0] fw[12], fg[12];
    string names[12];
    names = '{"packet_count", "byte_total", "duration_us", "min_gap", "mean_gap",
              "max_gap", "gap_deviation", "min_length", "mean_length", "max_length",
              "length_deviation", "overflow"};
    taken = 0;
    res.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (taken == 8) w = 6000;
      else if ((taken / 10) % 3 == 1) w = 0;
      else w = $urandom_range(0, 8);
      if (w > 0) begin
        res.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      taken++;
      got = '{res.packet_count, res.byte_total, res.duration_us, res.min_gap, res.mean_gap,
              res.max_gap, res.gap_deviation, res.min_length, res.mean_length,
              res.max_length, res.length_deviation, res.overflow};
      if (summaries_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected summary %p", got);
        continue;
      end
      want = summaries_due.pop_front();
      fw = '{want.packet_count, want.byte_total, want.duration_us, want.min_gap,
             want.mean_gap, want.max_gap, want.gap_deviation, want.min_length,
             want.mean_length, want.max_length, want.length_deviation, want.overflow};
      fg = '{got.packet_count, got.byte_total, got.duration_us, got.min_gap,
             got.mean_gap, got.max_gap, got.gap_deviation, got.min_length,
             got.mean_length, got.max_length, got.length_deviation, got.overflow};
      for (int i = 0; i < 12; i++)
        if (fw[i] !== fg[i]) begin
          errors++;
          if (errors <= 10)
            $display("summary %0d %s: expected %0d, got %0d", taken, names[i], fw[i], fg[i]);
        end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t dir[$];
    row_t r;
    int sent, flen, gstyle, lstyle;
    logic [TS_W-1:0] t;
    rst = 1'b1;
    pkt.valid <= 1'b0;
    pkt.timestamp_us <= '0;
    pkt.packet_length <= '0;
    pkt.last <= 1'b0;
    clear_flow();

    // single-packet flows at the extremes
    r = mk('0, '0, 1); r.known = 1;
    r.sum = '{16'd1, 32'd0, 40'd0, 40'd0, 40'd0, 40'd0, 40'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
    dir.push_back(r);
    r = mk('1, '1, 1); r.known = 1;
    r.sum = '{16'd1, 32'hFFFF, 40'd0, 40'd0, 40'd0, 40'd0, 40'd0, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'd0, 1'b0};
    dir.push_back(r);
    // largest gap, then a decreasing timestamp, then equal timestamps
    dir.push_back(mk('0, '0, 0));
    dir.push_back(mk('1, '1, 1));
    dir.push_back(mk(40'd100, 16'd10, 0));
    dir.push_back(mk(40'd50, 16'd20, 1));
    dir.push_back(mk(40'd5, 16'd1, 0));
    dir.push_back(mk(40'd5, 16'd2, 0));
    dir.push_back(mk(40'd5, 16'd3, 1));
    dir.push_back(mk(40'h55_5555_5555, 16'h5555, 0));
    dir.push_back(mk(40'hAA_AAAA_AAAA, 16'hAAAA, 0));
    dir.push_back(mk(40'hFF_FFFF_FFFF, 16'h0001, 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir[i]) send(dir[i]);

    sent = 0;
    while (sent < 600) begin
      sender_burst = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       flen = 1;
        1, 2:    flen = $urandom_range(11, 40);
        default: flen = $urandom_range(2, 10);
      endcase
      gstyle = $urandom_range(0, 3);
      lstyle = $urandom_range(0, 2);
      t = rand_ts();
      for (int i = 0; i < flen; i++) begin
        logic [LEN_W-1:0] len;
        case (lstyle)
          0: len = 16'($urandom);
          1: len = 16'($urandom_range(40, 1500));
          default: len = $urandom_range(0, 1) ? '1 : '0;
        endcase
        send(mk(t, len, i == flen - 1));
        sent++;
        if ($urandom_range(0, 19) == 0) t = rand_ts();
        else case (gstyle)
          0: t += 40'($urandom_range(0, 1000));
          1: t += rand_ts() >> $urandom_range(0, 20);
          2: t += 40'($urandom_range(0, 1));
          default: t += 40'($urandom_range(0, 100000));
        endcase
      end
    end
    pkt.valid <= 1'b0;

    while (summaries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
